[rtl/fst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fst_pkg
// Shared types and codes for the frequency scan table: command opcodes,
// result status codes, class constants and the controller/datapath buses.
// ----------------------------------------------------------------------------
package fst_pkg;

  localparam int unsigned FREQ_W   = 33;
  localparam int unsigned CLASS_W  = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 10;

  localparam logic [CLASS_W-1:0] CLASS_OTHER = 4'd7;
  localparam logic [CLASS_W-1:0] CLASS_MAX   = 4'd8;

  // Configuration register indexes
  localparam logic CFG_BAND_LOW  = 1'b0;
  localparam logic CFG_BAND_HIGH = 1'b1;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_LOAD   = 3'd1,
    OP_FINISH = 3'd2,
    OP_NEXT   = 3'd3,
    OP_FIND   = 3'd4
  } fst_op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_EMPTY      = 2'd1,
    STATUS_NOT_LOADED = 2'd2,
    STATUS_NOT_FOUND  = 2'd3
  } fst_status_t;

  typedef enum logic [1:0] {
    RD_SCAN  = 2'd0,
    RD_FIRST = 2'd1,
    RD_AFTER = 2'd2
  } fst_rd_sel_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECODE = 3'd1,
    S_SCAN   = 3'd2,
    S_FETCH  = 3'd3,
    S_DONE   = 3'd4
  } fst_state_t;

  typedef struct packed {
    logic [FREQ_W-1:0]  freq;
    logic [CLASS_W-1:0] cls;
  } fst_entry_t;

  // Controller -> datapath
  typedef struct packed {
    logic        capture;
    logic        clear;
    logic        store;
    logic        set_loaded;
    logic        scan_start;
    logic        rd_en;
    fst_rd_sel_t rd_sel;
    logic        out_load;
    logic        out_src_entry;
    fst_status_t out_status;
    logic        out_stored;
  } fst_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    fst_op_t op;
    logic    freq_zero;
    logic    cnt_zero;
    logic    loaded;
    logic    can_store;
    logic    issue_more;
    logic    rd_vld;
    logic    match;
  } fst_sts_t;

endpackage
`default_nettype wire

[rtl/fst_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fst_ctrl
// Command sequencer: decodes one transaction, drives the entry scan and
// fetch in the datapath, and hands the result to the output register.
// ----------------------------------------------------------------------------
module fst_ctrl
  import fst_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire fst_sts_t sts,
  output fst_cmd_t      cmd
);

  fst_state_t  state_r, state_nxt;
  fst_status_t status_r, status_nxt;
  logic        stored_r, stored_nxt;
  logic        src_entry_r, src_entry_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      status_r    <= STATUS_OK;
      stored_r    <= 1'b0;
      src_entry_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      stored_r    <= stored_nxt;
      src_entry_r <= src_entry_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (sts.op)
          OP_NEXT: begin
            if (sts.cnt_zero)       state_nxt = S_DONE;
            else if (sts.freq_zero) state_nxt = S_FETCH;
            else                    state_nxt = S_SCAN;
          end
          OP_FIND: begin
            state_nxt = sts.loaded ? S_SCAN : S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (sts.match) begin
          state_nxt = (sts.op == OP_NEXT) ? S_FETCH : S_DONE;
        end else if (!sts.issue_more && !sts.rd_vld) begin
          state_nxt = (sts.op == OP_NEXT) ? S_FETCH : S_DONE;
        end
      end
      S_FETCH: state_nxt = S_DONE;
      S_DONE: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and result bookkeeping
  always_comb begin
    cmd           = '0;
    cmd.rd_sel    = RD_SCAN;
    cmd.out_status = status_r;
    cmd.out_stored = stored_r;
    cmd.out_src_entry = src_entry_r;
    status_nxt    = status_r;
    stored_nxt    = stored_r;
    src_entry_nxt = src_entry_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture   = 1'b1;
          status_nxt    = STATUS_OK;
          stored_nxt    = 1'b0;
          src_entry_nxt = 1'b0;
        end
      end
      S_DECODE: begin
        case (sts.op)
          OP_CLEAR: cmd.clear = 1'b1;
          OP_LOAD: begin
            if (sts.can_store) begin
              cmd.store  = 1'b1;
              stored_nxt = 1'b1;
            end
          end
          OP_FINISH: begin
            if (!sts.loaded) begin
              if (sts.cnt_zero) status_nxt = STATUS_EMPTY;
              else              cmd.set_loaded = 1'b1;
            end
          end
          OP_NEXT: begin
            if (sts.cnt_zero) begin
              status_nxt = STATUS_EMPTY;
            end else if (sts.freq_zero) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_FIRST;
            end else begin
              cmd.scan_start = 1'b1;
            end
          end
          OP_FIND: begin
            if (sts.loaded) cmd.scan_start = 1'b1;
            else            status_nxt = STATUS_NOT_LOADED;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (sts.match) begin
          // Hold the matched entry for find; step past it for next
          if (sts.op == OP_NEXT) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_AFTER;
          end else begin
            src_entry_nxt = 1'b1;
          end
        end else if (sts.issue_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_SCAN;
        end else if (!sts.rd_vld) begin
          if (sts.op == OP_NEXT) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_FIRST;
          end else begin
            status_nxt = STATUS_NOT_FOUND;
          end
        end
      end
      S_FETCH: src_entry_nxt = 1'b1;
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[rtl/fst_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fst_dp
// Datapath: band registers, entry memory with registered read, entry count,
// loaded mark, scan address and compare, and the output register.
// ----------------------------------------------------------------------------
module fst_dp
  import fst_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [FREQ_W-1:0]    cfg_wdata,
  input  wire logic [2:0]           in_command,
  input  wire logic [FREQ_W-1:0]    in_freq_in,
  input  wire logic [CLASS_W-1:0]   in_class_in,
  input  wire fst_cmd_t             cmd,
  output fst_sts_t                  sts,
  output logic [STATUS_W-1:0]       out_status,
  output logic [FREQ_W-1:0]         out_freq_out,
  output logic [CLASS_W-1:0]        out_class_out,
  output logic                      out_entry_stored,
  output logic [INDEX_W-1:0]        out_entry_index
);

  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [FREQ_W-1:0]  band_lo_r, band_hi_r;
  fst_op_t            op_r;
  logic [FREQ_W-1:0]  freq_r;
  logic [CLASS_W-1:0] class_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               loaded_r;
  logic [CNT_W-1:0]   addr_r;
  fst_entry_t         mem [TABLE_ENTRIES];
  fst_entry_t         rd_data_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               rd_vld_r;

  logic [STATUS_W-1:0] out_status_r;
  logic [FREQ_W-1:0]   out_freq_r;
  logic [CLASS_W-1:0]  out_class_r;
  logic                out_stored_r;
  logic [INDEX_W-1:0]  out_index_r;

  fst_entry_t       wr_entry;
  logic [CNT_W-1:0] after_cnt;
  logic [IDX_W-1:0] after_idx;
  logic [IDX_W-1:0] rd_addr;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_lo_r <= '0;
      band_hi_r <= '1;
      cnt_r     <= '0;
      loaded_r  <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BAND_LOW) band_lo_r <= cfg_wdata;
        else                           band_hi_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        cnt_r    <= '0;
        loaded_r <= 1'b0;
      end else begin
        if (cmd.store)      cnt_r    <= cnt_r + CNT_W'(1);
        if (cmd.set_loaded) loaded_r <= 1'b1;
      end
      rd_vld_r <= cmd.rd_en;
    end
  end

  // Latch the command and step the scan address
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= fst_op_t'(in_command);
      freq_r  <= in_freq_in;
      class_r <= in_class_in;
    end
    if (cmd.scan_start) begin
      addr_r <= '0;
    end else if (cmd.rd_en && cmd.rd_sel == RD_SCAN) begin
      addr_r <= addr_r + CNT_W'(1);
    end
  end

  // Map unknown classes to other
  always_comb begin
    wr_entry.freq = freq_r;
    wr_entry.cls  = (class_r > CLASS_MAX) ? CLASS_OTHER : class_r;
  end

  // Entry after the matched one, wrapping at the fill count
  always_comb begin
    after_cnt = CNT_W'(rd_idx_r) + CNT_W'(1);
    after_idx = (after_cnt >= cnt_r) ? '0 : after_cnt[IDX_W-1:0];
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_SCAN:  rd_addr = addr_r[IDX_W-1:0];
      RD_FIRST: rd_addr = '0;
      RD_AFTER: rd_addr = after_idx;
      default:  rd_addr = '0;
    endcase
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store) mem[cnt_r[IDX_W-1:0]] <= wr_entry;
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

  always_comb begin
    sts.op         = op_r;
    sts.freq_zero  = (freq_r == '0);
    sts.cnt_zero   = (cnt_r == '0);
    sts.loaded     = loaded_r;
    sts.can_store  = !loaded_r && (freq_r >= band_lo_r) && (freq_r <= band_hi_r) &&
                     (cnt_r < CNT_W'(TABLE_ENTRIES));
    sts.issue_more = (addr_r < cnt_r);
    sts.rd_vld     = rd_vld_r;
    sts.match      = rd_vld_r && (rd_data_r.freq == freq_r);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_stored_r <= cmd.out_stored;
      if (cmd.out_src_entry) begin
        out_freq_r  <= rd_data_r.freq;
        out_class_r <= rd_data_r.cls;
        out_index_r <= INDEX_W'(rd_idx_r);
      end else begin
        out_freq_r  <= '0;
        out_class_r <= '0;
        out_index_r <= '0;
      end
    end
  end

  assign out_status       = out_status_r;
  assign out_freq_out     = out_freq_r;
  assign out_class_out    = out_class_r;
  assign out_entry_stored = out_stored_r;
  assign out_entry_index  = out_index_r;

endmodule
`default_nettype wire

[rtl/frequency_scan_table_top.sv]
`default_nettype none
// Steps from input accept to out_valid: decode then done for clear, load, finish, unused
//   codes, next on an empty table and find while not loaded; decode, fetch and done for
//   next from zero; a scan reads one entry per cycle through the memory read port.
// Transactions: one at a time, the next taken in the cycle after the result loads.
// Reset (rst_n, synchronous): empty, not loaded, band open; entry memory not cleared.
// ----------------------------------------------------------------------------
// frequency_scan_table_top
// Table of scan frequencies with class codes: clear, load, finish, next and
// find transactions, each answered by exactly one result transaction.
// ----------------------------------------------------------------------------
module frequency_scan_table_top
  import fst_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Configuration write port
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [FREQ_W-1:0]   cfg_wdata,
  // Command channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          in_command,
  input  wire logic [FREQ_W-1:0]   in_freq_in,
  input  wire logic [CLASS_W-1:0]  in_class_in,
  // Result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic [FREQ_W-1:0]        out_freq_out,
  output logic [CLASS_W-1:0]       out_class_out,
  output logic                     out_entry_stored,
  output logic [INDEX_W-1:0]       out_entry_index
);

  // Command and status buses between sequencer and datapath
  fst_cmd_t cmd;
  fst_sts_t sts;

  // Sequencer: takes a transaction only when idle; the output register lets
  // a new command start while the previous result still waits downstream.
  fst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: entry memory, band check, scan compare and result register.
  fst_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_command       (in_command),
    .in_freq_in       (in_freq_in),
    .in_class_in      (in_class_in),
    .cmd              (cmd),
    .sts              (sts),
    .out_status       (out_status),
    .out_freq_out     (out_freq_out),
    .out_class_out    (out_class_out),
    .out_entry_stored (out_entry_stored),
    .out_entry_index  (out_entry_index)
  );

endmodule
`default_nettype wire
